/* hw/rtl/ttfd_pkg.sv */
// Shared types, codes and channel widening helpers for the tiled texel decoder.
`timescale 1ns / 1ps
`default_nettype none

package ttfd_pkg;

    localparam int COORD_W    = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // texel format codes
    localparam logic [2:0] FMT_I4     = 3'd0;
    localparam logic [2:0] FMT_I8     = 3'd1;
    localparam logic [2:0] FMT_IA4    = 3'd2;
    localparam logic [2:0] FMT_RGB565 = 3'd3;
    localparam logic [2:0] FMT_RGB5A3 = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
        logic               last;
        logic               done;
    } pixel_t;

    // up to two pixels decoded from one byte, in output order
    typedef struct packed {
        logic   v0;
        logic   v1;
        pixel_t p0;
        pixel_t p1;
    } pair_t;

    function automatic logic [7:0] widen3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tiled_texel_format_decoder.sv */
// Tiled texel format decoder: texel bytes of a tiled texture in, RGBA8 pixels out.
//
// Input channel: data_byte with data_valid/data_stall, one byte per beat in
// file order. Output channel: one pixel per beat on pixel_valid/pixel_stall
// with its coordinates, color, last_of_run and image_done.
// Configuration: cfg_write with cfg_index/cfg_data; index 0 format, 1 width,
// 2 height. A write to index 0, 1 or 2 restarts the image at the first tile.
// Write only while the block is idle.
// The pixels of an accepted byte are registered in the two-slot pixel buffer,
// then in the output register. Throughput: one byte per cycle for I8, IA4,
// RGB565 and RGB5A3 when not stalled (16-bit formats take two bytes per pixel);
// for I4 the single-pixel output channel stalls the input while both pixels of
// a byte wait. Bytes only in padded tiles or holding a high byte give no pixel.
// Reset: format I4, width and height 1, counters cleared, no pixel pending.
// A stalled output holds its pixel; data_stall rises as soon as the two-slot
// pixel buffer in front of the output register cannot drain.
`timescale 1ns / 1ps
`default_nettype none

module tiled_texel_format_decoder #(
    parameter int MAX_DIMENSION = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [ttfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           data_valid,
    output logic                                data_stall,
    input  wire logic [7:0]                     data_byte,
    output logic                                pixel_valid,
    input  wire logic                           pixel_stall,
    output logic [ttfd_pkg::COORD_W-1:0]        pixel_x,
    output logic [ttfd_pkg::COORD_W-1:0]        pixel_y,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic [7:0]                          alpha,
    output logic                                last_of_run,
    output logic                                image_done
);
    import ttfd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION) + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (int'(v) > MAX_DIMENSION)
            return DIM_W'(MAX_DIMENSION);
        else
            return DIM_W'(v);
    endfunction

    logic [2:0]       fmt_reg;
    logic [DIM_W-1:0] w_reg, h_reg, w_m1, h_m1;
    logic             cfg_hit;

    pair_t  dec_pair;
    logic   pv0_reg, pv1_reg;
    pixel_t pix0_reg, pix1_reg;
    logic   out_valid_reg;
    pixel_t out_pix_reg;

    logic   take, out_free, move, drain;
    pixel_t sel_pix;

    assign cfg_hit = cfg_write && (cfg_index inside {CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_I4;
            w_reg   <= DIM_W'(1);
            h_reg   <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FORMAT: fmt_reg <= cfg_data[2:0];
                CFG_WIDTH:  w_reg   <= clamp_dim(cfg_data);
                CFG_HEIGHT: h_reg   <= clamp_dim(cfg_data);
                default:    ;
            endcase
        end
    end

    assign w_m1 = w_reg - DIM_W'(1);
    assign h_m1 = h_reg - DIM_W'(1);

    ttfd_unpack #(
        .DIM_W (DIM_W)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_hit),
        .fmt       (fmt_reg),
        .width     (w_reg),
        .height    (h_reg),
        .take      (take),
        .data_byte (data_byte),
        .pair      (dec_pair)
    );

    // pixel buffer drains one pixel per beat into the output register
    assign out_free = !out_valid_reg || !pixel_stall;
    assign move     = out_free && (pv0_reg || pv1_reg);
    assign sel_pix  = pv0_reg ? pix0_reg : pix1_reg;
    // buffer is empty after this cycle
    assign drain    = !(pv0_reg && pv1_reg) && (!(pv0_reg || pv1_reg) || out_free);

    assign data_stall = !drain;
    assign take       = data_valid && drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv0_reg <= 1'b0;
            pv1_reg <= 1'b0;
        end
        else if (take)
        begin
            pv0_reg <= dec_pair.v0;
            pv1_reg <= dec_pair.v1;
        end
        else if (move)
        begin
            if (pv0_reg)
                pv0_reg <= 1'b0;
            else
                pv1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix0_reg <= dec_pair.p0;
            pix1_reg <= dec_pair.p1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= move;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            out_pix_reg <= sel_pix;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_pix_reg.x;
    assign pixel_y     = out_pix_reg.y;
    assign red         = out_pix_reg.r;
    assign green       = out_pix_reg.g;
    assign blue        = out_pix_reg.b;
    assign alpha       = out_pix_reg.a;
    assign last_of_run = out_pix_reg.last;
    assign image_done  = out_pix_reg.done;

    // a full pixel buffer must hold off the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (pv0_reg && pv1_reg) |-> data_stall)
        else $error("pixel buffer full but input not stalled");

    // held output pixel does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pixel_stall) |=> (out_valid_reg && $stable(out_pix_reg)))
        else $error("stalled output pixel changed");

    // bottom-right pixel always closes the run of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && image_done) |-> last_of_run)
        else $error("image_done without last_of_run");

    // image_done only at the bottom-right corner
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && image_done) |->
            (pixel_x == COORD_W'(w_m1) && pixel_y == COORD_W'(h_m1)))
        else $error("image_done away from the corner");

endmodule

`default_nettype wire

/* hw/rtl/ttfd_unpack.sv */
// Tile position counters and byte-to-pixel decode for the tiled texel decoder.
`timescale 1ns / 1ps
`default_nettype none

module ttfd_unpack #(
    parameter int DIM_W = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                clear,
    input  wire logic [2:0]          fmt,
    input  wire logic [DIM_W-1:0]    width,
    input  wire logic [DIM_W-1:0]    height,
    input  wire logic                take,
    input  wire logic [7:0]          data_byte,
    output ttfd_pkg::pair_t          pair
);
    import ttfd_pkg::*;

    logic [DIM_W-1:0] tcb_reg, tcb_next;
    logic [DIM_W-1:0] trb_reg, trb_next;
    logic [2:0]       row_reg, row_next;
    logic [2:0]       col_reg, col_next;
    logic [7:0]       hold_reg, hold_next;
    logic             pend_reg, pend_next;

    logic [DIM_W-1:0] x0, x1, y, w_m1, h_m1;
    logic [DIM_W-1:0] tcb_sum, trb_sum;
    logic [3:0]       step, tw, th, col_sum, row_sum;
    logic             emit, adv;
    logic             vis0, vis1;
    logic [15:0]      texel;
    logic [7:0]       r0, g0, b0, a0, a1;

    assign x0    = tcb_reg + DIM_W'(col_reg);
    assign x1    = x0 + DIM_W'(1);
    assign y     = trb_reg + DIM_W'(row_reg);
    assign w_m1  = width - DIM_W'(1);
    assign h_m1  = height - DIM_W'(1);
    assign texel = {hold_reg, data_byte};

    always_comb
    begin
        step = 4'd1;
        tw   = 4'd8;
        th   = 4'd4;
        emit = 1'b0;
        adv  = 1'b0;
        r0   = 8'hFF;
        g0   = 8'hFF;
        b0   = 8'hFF;
        a0   = 8'hFF;
        a1   = widen4(data_byte[3:0]);
        hold_next = hold_reg;
        pend_next = pend_reg;
        case (fmt)
            FMT_I4:
            begin
                step = 4'd2;
                th   = 4'd8;
                a0   = widen4(data_byte[7:4]);
                emit = 1'b1;
                adv  = 1'b1;
            end
            FMT_I8:
            begin
                a0   = data_byte;
                emit = 1'b1;
                adv  = 1'b1;
            end
            FMT_IA4:
            begin
                r0   = widen4(data_byte[3:0]);
                g0   = r0;
                b0   = r0;
                a0   = widen4(data_byte[7:4]);
                emit = 1'b1;
                adv  = 1'b1;
            end
            FMT_RGB565, FMT_RGB5A3:
            begin
                tw = 4'd4;
                if (!pend_reg)
                begin
                    hold_next = data_byte;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    emit = 1'b1;
                    adv  = 1'b1;
                    if (fmt == FMT_RGB565)
                    begin
                        r0 = widen5(texel[15:11]);
                        g0 = widen6(texel[10:5]);
                        b0 = widen5(texel[4:0]);
                    end
                    else if (texel[15])
                    begin
                        r0 = widen5(texel[14:10]);
                        g0 = widen5(texel[9:5]);
                        b0 = widen5(texel[4:0]);
                    end
                    else
                    begin
                        a0 = widen3(texel[14:12]);
                        r0 = widen4(texel[11:8]);
                        g0 = widen4(texel[7:4]);
                        b0 = widen4(texel[3:0]);
                    end
                end
            end
            default:
            begin
                // unknown format: byte is dropped, state untouched
            end
        endcase
    end

    // second pixel exists only for I4
    assign vis0 = emit && (x0 < width) && (y < height);
    assign vis1 = emit && (fmt == FMT_I4) && (x1 < width) && (y < height);

    always_comb
    begin
        pair.v0      = vis0;
        pair.v1      = vis1;
        pair.p0.x    = COORD_W'(x0);
        pair.p0.y    = COORD_W'(y);
        pair.p0.r    = r0;
        pair.p0.g    = g0;
        pair.p0.b    = b0;
        pair.p0.a    = a0;
        pair.p0.last = !vis1;
        pair.p0.done = (x0 == w_m1) && (y == h_m1);
        pair.p1.x    = COORD_W'(x1);
        pair.p1.y    = COORD_W'(y);
        pair.p1.r    = 8'hFF;
        pair.p1.g    = 8'hFF;
        pair.p1.b    = 8'hFF;
        pair.p1.a    = a1;
        pair.p1.last = 1'b1;
        pair.p1.done = (x1 == w_m1) && (y == h_m1);
    end

    assign col_sum = {1'b0, col_reg} + step;
    assign row_sum = {1'b0, row_reg} + 4'd1;
    assign tcb_sum = tcb_reg + DIM_W'(tw);
    assign trb_sum = trb_reg + DIM_W'(th);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        tcb_next = tcb_reg;
        trb_next = trb_reg;
        if (adv)
        begin
            if (col_sum < tw)
            begin
                col_next = col_sum[2:0];
            end
            else
            begin
                col_next = 3'd0;
                if (row_sum < th)
                begin
                    row_next = row_sum[2:0];
                end
                else
                begin
                    row_next = 3'd0;
                    if (tcb_sum < width)
                    begin
                        tcb_next = tcb_sum;
                    end
                    else
                    begin
                        tcb_next = '0;
                        trb_next = (trb_sum >= height) ? '0 : trb_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcb_reg  <= '0;
            trb_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            hold_reg <= '0;
            pend_reg <= 1'b0;
        end
        else if (clear)
        begin
            tcb_reg  <= '0;
            trb_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            hold_reg <= '0;
            pend_reg <= 1'b0;
        end
        else if (take)
        begin
            tcb_reg  <= tcb_next;
            trb_reg  <= trb_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            hold_reg <= hold_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

/* verif/tiled_texel_format_decoder_test.sv */
// Self-checking testbench for the tiled texel format decoder: random bytes in, pixels checked.
`timescale 1ns / 1ps

module tiled_texel_format_decoder_test;
    import ttfd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_DIM       = 1024;
    localparam int TILE_BYTES    = 32;
    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 12;
    localparam int TIMEOUT_NS    = 12_000_000;

    // codes the package leaves unnamed
    localparam logic [2:0]           FMT_LAST_CODE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_REG_WRITE,
        OP_SETTLE
    } feed_kind_e;

    typedef struct {
        feed_kind_e             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        int                     gap;
    } feed_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   data_valid = 1'b0;
    logic                   data_stall;
    logic [7:0]             data_byte = '0;
    logic                   pixel_valid;
    logic                   pixel_stall = 1'b0;
    logic [COORD_W-1:0]     pixel_x;
    logic [COORD_W-1:0]     pixel_y;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             alpha;
    logic                   last_of_run;
    logic                   image_done;

    feed_op_t   texel_feed[$];
    pixel_t     pixels_due[$];
    int         quiet_cycles = 0;
    int         mismatches = 0;
    int         gap_elapsed = 0;
    int         stall_left = 0;
    int         calm_left = 0;

    // decoder state as seen by the predictor
    logic [2:0]             cur_fmt = FMT_I4;
    logic [CFG_DATA_W-1:0]  reg_width = 11'd1;
    logic [CFG_DATA_W-1:0]  reg_height = 11'd1;
    logic [11:0]            tile_x0 = '0;
    logic [11:0]            tile_y0 = '0;
    logic [3:0]             sub_row = '0;
    logic [3:0]             sub_col = '0;
    logic [7:0]             held_hi = '0;
    logic                   hi_waiting = 1'b0;

    tiled_texel_format_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_valid  (data_valid),
        .data_stall  (data_stall),
        .data_byte   (data_byte),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .last_of_run (last_of_run),
        .image_done  (image_done)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [CFG_DATA_W-1:0] dim_limit(input logic [CFG_DATA_W-1:0] v);
        if (v == 0)
            return 11'd1;
        if (v > MAX_DIM)
            return 11'(MAX_DIM);
        return v;
    endfunction

    // bit replication of a narrow channel up to eight bits
    function automatic logic [7:0] expand(input logic [5:0] v, input int bits);
        logic [7:0] wide;
        for (int k = 0; k < 8; k++)
            wide[7 - k] = v[bits - 1 - (k % bits)];
        return wide;
    endfunction

    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 93)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic int image_bytes(input logic [2:0] fmt, input logic [10:0] w,
                                       input logic [10:0] h);
        int tw;
        int th;
        tw = (fmt == FMT_RGB565 || fmt == FMT_RGB5A3) ? 4 : 8;
        th = (fmt == FMT_I4) ? 8 : tw == 4 ? 4 : 4;
        return ((dim_limit(w) + tw - 1) / tw) * ((dim_limit(h) + th - 1) / th) * TILE_BYTES;
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 0;
        if (roll < 10)
            return $urandom_range(MAX_DIM + 1, 2047);
        if (roll < 15)
            return MAX_DIM;
        if (roll < 25)
            return 1;
        return $urandom_range(2, 12);
    endfunction

    task automatic add_byte(input logic [7:0] value, input bit bursty);
        feed_op_t op;
        op.kind  = OP_BYTE;
        op.index = '0;
        op.value = 11'(value);
        op.gap   = (bursty || $urandom_range(0, 1) == 0) ? 0 : pick_len();
        texel_feed.push_back(op);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        feed_op_t op;
        op.kind  = OP_REG_WRITE;
        op.index = index;
        op.value = value;
        op.gap   = 0;
        texel_feed.push_back(op);
    endtask

    task automatic add_settle();
        feed_op_t op;
        op.kind  = OP_SETTLE;
        op.index = '0;
        op.value = '0;
        op.gap   = 0;
        texel_feed.push_back(op);
    endtask

    task automatic add_pixel(input logic [11:0] x, input logic [11:0] y,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a, inout int n);
        pixel_t pix;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        w = dim_limit(reg_width);
        h = dim_limit(reg_height);
        if (x >= w || y >= h)
            return;
        pix.x    = x[COORD_W-1:0];
        pix.y    = y[COORD_W-1:0];
        pix.r    = r;
        pix.g    = g;
        pix.b    = b;
        pix.a    = a;
        pix.last = 1'b0;
        pix.done = (x == w - 1 && y == h - 1);
        pixels_due.push_back(pix);
        n++;
    endtask

    // tiles run left to right, then down; wraps to the top after the last tile row
    task automatic advance(input int step, input int tw, input int th);
        sub_col = 4'(sub_col + step);
        if (sub_col < tw)
            return;
        sub_col = '0;
        sub_row = sub_row + 4'd1;
        if (sub_row < th)
            return;
        sub_row = '0;
        tile_x0 = 12'(tile_x0 + tw);
        if (tile_x0 < dim_limit(reg_width))
            return;
        tile_x0 = '0;
        tile_y0 = 12'(tile_y0 + th);
        if (tile_y0 >= dim_limit(reg_height))
            tile_y0 = '0;
    endtask

    task automatic decode_byte(input logic [7:0] d);
        logic [11:0] px;
        logic [11:0] py;
        logic [15:0] word;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        int          n;
        n  = 0;
        px = tile_x0 + 12'(sub_col);
        py = tile_y0 + 12'(sub_row);
        case (cur_fmt)
            FMT_I4:
            begin
                add_pixel(px, py, 8'hFF, 8'hFF, 8'hFF, expand(6'(d[7:4]), 4), n);
                add_pixel(px + 12'd1, py, 8'hFF, 8'hFF, 8'hFF, expand(6'(d[3:0]), 4), n);
                advance(2, 8, 8);
            end
            FMT_I8:
            begin
                add_pixel(px, py, 8'hFF, 8'hFF, 8'hFF, d, n);
                advance(1, 8, 4);
            end
            FMT_IA4:
            begin
                r = expand(6'(d[3:0]), 4);
                add_pixel(px, py, r, r, r, expand(6'(d[7:4]), 4), n);
                advance(1, 8, 4);
            end
            FMT_RGB565, FMT_RGB5A3:
            begin
                if (!hi_waiting)
                begin
                    held_hi    = d;
                    hi_waiting = 1'b1;
                end
                else
                begin
                    hi_waiting = 1'b0;
                    word = {held_hi, d};
                    if (cur_fmt == FMT_RGB565)
                    begin
                        r = expand(6'(word[15:11]), 5);
                        g = expand(word[10:5], 6);
                        b = expand(6'(word[4:0]), 5);
                        a = 8'hFF;
                    end
                    else if (word[15])
                    begin
                        r = expand(6'(word[14:10]), 5);
                        g = expand(6'(word[9:5]), 5);
                        b = expand(6'(word[4:0]), 5);
                        a = 8'hFF;
                    end
                    else
                    begin
                        a = expand(6'(word[14:12]), 3);
                        r = expand(6'(word[11:8]), 4);
                        g = expand(6'(word[7:4]), 4);
                        b = expand(6'(word[3:0]), 4);
                    end
                    add_pixel(px, py, r, g, b, a, n);
                    advance(1, 4, 4);
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            pixels_due[pixels_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // byte and register-write driver
    always @(posedge clk)
    begin : byte_driver
        logic     next_valid;
        logic     next_write;
        feed_op_t op;
        if (rst_n)
        begin
            next_valid = data_valid && data_stall;
            next_write = 1'b0;
            if (!next_valid && texel_feed.size() != 0)
            begin
                op = texel_feed[0];
                case (op.kind)
                    OP_BYTE:
                    begin
                        if (gap_elapsed < op.gap)
                            gap_elapsed++;
                        else
                        begin
                            next_valid  = 1'b1;
                            data_byte  <= op.value[7:0];
                            gap_elapsed = 0;
                            void'(texel_feed.pop_front());
                        end
                    end
                    OP_REG_WRITE:
                    begin
                        if (!data_valid && quiet_cycles >= SETTLE_CYCLES)
                        begin
                            next_write = 1'b1;
                            cfg_index <= op.index;
                            cfg_data  <= op.value;
                            void'(texel_feed.pop_front());
                        end
                    end
                    default:
                    begin
                        if (!data_valid && quiet_cycles >= SETTLE_CYCLES)
                            void'(texel_feed.pop_front());
                    end
                endcase
            end
            data_valid <= next_valid;
            cfg_write  <= next_write;
        end
    end

    // output stall: short and long stalls, with calm stretches in between
    always @(posedge clk)
    begin : stall_driver
        logic next_stall;
        int   roll;
        next_stall = 1'b0;
        if (stall_left > 0)
        begin
            next_stall = 1'b1;
            stall_left--;
        end
        else if (calm_left > 0)
            calm_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                calm_left = $urandom_range(20, 200);
            else if (roll < 30)
            begin
                next_stall = 1'b1;
                stall_left = pick_len() - 1;
            end
        end
        pixel_stall <= next_stall;
    end

    always @(posedge clk)
    begin : pixel_monitor
        pixel_t want;
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("pixel at (%0d,%0d) with none expected", pixel_x, pixel_y);
                    mismatches++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("red", want.r, red);
                    check_field("green", want.g, green);
                    check_field("blue", want.b, blue);
                    check_field("alpha", want.a, alpha);
                    check_field("last_of_run", want.last, last_of_run);
                    check_field("image_done", want.done, image_done);
                end
            end
            if (cfg_write && cfg_index != CFG_UNUSED)
            begin
                case (cfg_index)
                    CFG_FORMAT: cur_fmt    = cfg_data[2:0];
                    CFG_WIDTH:  reg_width  = cfg_data;
                    default:    reg_height = cfg_data;
                endcase
                // any known write restarts the image
                tile_x0    = '0;
                tile_y0    = '0;
                sub_row    = '0;
                sub_col    = '0;
                held_hi    = '0;
                hi_waiting = 1'b0;
            end
            if (data_valid && !data_stall)
                decode_byte(data_byte);
            quiet_cycles <= (pixels_due.size() == 0 && !data_valid && !pixel_valid)
                            ? quiet_cycles + 1 : 0;
        end
    end

    initial
    begin : stimulus
        logic [CFG_IDX_W-1:0]  order[3];
        logic [CFG_DATA_W-1:0] vals[3];
        int items;
        int phase;
        int n;
        int fmt;
        int full;
        int first;
        int settle_at;
        bit bursty;

        order = '{CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT};
        fmt = FMT_I4;

        // reset configuration, then zero sizes (read as 1x1)
        add_byte(8'hF0, 1'b0);
        add_write(CFG_WIDTH, 11'd0);
        add_write(CFG_HEIGHT, 11'd0);
        add_byte(8'h0F, 1'b0);
        add_write(CFG_FORMAT, 11'(FMT_I8));
        add_write(CFG_WIDTH, 11'd9);
        add_write(CFG_HEIGHT, 11'd5);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_write(CFG_FORMAT, 11'(FMT_IA4));
        add_byte(8'h0F, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_write(CFG_FORMAT, 11'(FMT_RGB565));
        foreach (vals[k])
        begin
        end
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'h1F, 1'b0);
        // 5:5:5 with top bit set, then 3-bit alpha with 4:4:4
        add_write(CFG_FORMAT, 11'(FMT_RGB5A3));
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        // high byte held across a write to the unused index
        add_byte(8'h12, 1'b0);
        add_write(CFG_UNUSED, 11'h5A5);
        add_byte(8'h34, 1'b0);
        // unknown format with upper data bits set: byte ignored
        add_write(CFG_FORMAT, 11'h7F8 | 11'(FMT_LAST_CODE));
        add_byte(8'hAA, 1'b0);

        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            bursty = ($urandom_range(0, 3) == 0);
            if (phase > 0 && $urandom_range(0, 99) < 8)
            begin
                // stray write: the image must carry on where it was
                add_write(CFG_UNUSED, 11'($urandom_range(0, 2047)));
                n = $urandom_range(8, 40);
            end
            else
            begin
                if (phase == 0)
                begin
                    fmt     = FMT_I4;
                    vals[1] = 11'd2047;
                    vals[2] = 11'(MAX_DIM + 1);
                end
                else
                begin
                    fmt = ($urandom_range(0, 99) < 8)
                          ? $urandom_range(int'(FMT_RGB5A3) + 1, int'(FMT_LAST_CODE))
                          : $urandom_range(int'(FMT_I4), int'(FMT_RGB5A3));
                    vals[1] = 11'(pick_dim());
                    vals[2] = 11'(pick_dim());
                end
                vals[0] = 11'($urandom_range(0, 2047));
                vals[0][2:0] = 3'(fmt);
                first = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                    add_write(order[(first + k) % 3], vals[(first + k) % 3]);
                full = image_bytes(3'(fmt), vals[1], vals[2]);
                if (fmt > FMT_RGB5A3)
                    n = $urandom_range(3, 8);
                else if (full <= 128)
                    n = full + $urandom_range(0, full / 2);
                else
                    n = $urandom_range(24, 64);
            end
            settle_at = (phase == 1 || $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : -1;
            for (int k = 0; k < n; k++)
            begin
                if (k == settle_at)
                    add_settle();
                add_byte(8'($urandom_range(0, 255)), bursty);
            end
            if (fmt <= FMT_RGB5A3)
                items += n;
            phase++;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (texel_feed.size() != 0 || quiet_cycles < DRAIN_CYCLES);

        if (mismatches == 0)
            $display("tiled_texel_format_decoder_test passed");
        else
            $display("tiled_texel_format_decoder_test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tiled_texel_format_decoder_test failed");
        $finish;
    end

endmodule
